[rtl/core/tmsf_pkg.sv]
package tmsf_pkg;

    // Field widths
    localparam int RAW_W = 8;
    localparam int VAL_W = 9;
    localparam int VAL_MAX = 511;

    // Default window depth
    localparam int WINDOW_SIZE_DEF = 8;

    // Temperature scaling: ((500*x) >> 8) - 10, floored at zero
    localparam int TEMP_GAIN = 500;
    localparam int TEMP_SHIFT = 8;
    localparam int TEMP_OFFSET = 10;

    // Voltage scaling: x*90/50 == x*9/5, done as (x*58986) >> 15.
    // Exact for every 8-bit x: the error stays below 0.03 of one count.
    localparam int VOLT_RECIP = 58986;
    localparam int VOLT_SHIFT = 15;
    localparam int VOLT_OFFSET = 7;

    // Reciprocal shift for the trimmed-mean divide
    localparam int DIV_SHIFT = 16;

endpackage

[rtl/core/trimmed_mean_sensor_filter_unit.sv]
// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+-------------------------------------
// input    | in        | i_in_valid / o_in_stall    | i_raw_sample[7:0]
// output   | out       | o_out_valid / i_out_stall  | o_filtered_value[8:0], o_window_mean[8:0]
// config   | in        | i_cfg_valid / o_cfg_ready  | i_cfg_data (scale_mode)
//
// Items are taken one at a time: the input transfer, one full rotation of the cell row past
// the sum/min/max accumulator, then trim, reciprocal multiply, quotient fix-up and blend;
// o_out_valid rises when the blend step stores its result, and a new input is taken after that.
// Synchronous active-low reset zeroes the window cells, previous output and scale_mode.
// o_in_stall is high while an item is in flight; a stalled output holds its register, and
// the next result parks in the blend step until the waiting one has been transferred.
module trimmed_mean_sensor_filter_unit #(
    parameter int WINDOW_SIZE = tmsf_pkg::WINDOW_SIZE_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [tmsf_pkg::RAW_W-1:0]   i_raw_sample,
    // output channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [tmsf_pkg::VAL_W-1:0]   o_filtered_value,
    output logic [tmsf_pkg::VAL_W-1:0]   o_window_mean,
    // config channel
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic                         i_cfg_data
);

    localparam int VAL_W   = tmsf_pkg::VAL_W;
    localparam int CNT_W   = $clog2(WINDOW_SIZE);
    localparam int SUM_W   = VAL_W + $clog2(WINDOW_SIZE);
    localparam int DIVISOR = WINDOW_SIZE - 2;
    localparam int RECIP   = (1 << tmsf_pkg::DIV_SHIFT) / DIVISOR;
    localparam int RECIP_W = tmsf_pkg::DIV_SHIFT + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_TRIM,
        S_MUL,
        S_FIX,
        S_BLEND
    } t_state;

    t_state                 r_state;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_mode;
    logic [VAL_W-1:0]       r_prev;
    logic                   r_out_valid;
    logic [VAL_W-1:0]       r_filt;
    logic [VAL_W-1:0]       r_mean_out;

    logic [SUM_W-1:0]       r_sum;
    logic [VAL_W-1:0]       r_hi;
    logic [VAL_W-1:0]       r_lo;
    logic [SUM_W-1:0]       r_num;
    logic [SUM_W-1:0]       r_quo0;
    logic [VAL_W-1:0]       r_mean;

    logic [SUM_W-1:0]       n_sum;
    logic [VAL_W-1:0]       n_hi;
    logic [VAL_W-1:0]       n_lo;

    logic                   w_in_xfer;
    logic                   w_out_xfer;
    logic                   w_out_free;
    logic                   w_scan_last;
    logic                   w_shift;
    logic [VAL_W-1:0]       w_scaled;
    logic [VAL_W-1:0]       w_head;
    logic [VAL_W-1:0]       w_tap [WINDOW_SIZE];
    logic [VAL_W-1:0]       w_scan_val;

    logic [PROD_W-1:0]      w_prod;
    logic [PROD_W-1:0]      w_prod_shr;
    logic [SUM_W-1:0]       w_qd;
    logic [SUM_W-1:0]       w_rem;
    logic [SUM_W-1:0]       w_quo;

    logic [VAL_W:0]         w_val_ext;
    logic [VAL_W-1:0]       w_val;
    logic [VAL_W:0]         w_blend_sum;
    logic [VAL_W:0]         w_blend_ext;
    logic [VAL_W-1:0]       w_blend;
    logic [VAL_W-1:0]       w_result;

    // handshakes
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_xfer   = i_in_valid && !o_in_stall;
    assign w_out_xfer  = r_out_valid && !i_out_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;

    assign o_out_valid      = r_out_valid;
    assign o_filtered_value = r_filt;
    assign o_window_mean    = r_mean_out;

    // input scaling straight into the head of the cell row
    tmsf_scale u_scale (
        .i_mode   (r_mode),
        .i_raw    (i_raw_sample),
        .o_scaled (w_scaled)
    );

    // The window only matters as a set, so the ring becomes a shift row: a new sample
    // pushes out the oldest. During the scan the row rotates, tail feeding head, and
    // after WINDOW_SIZE steps it is back in place.
    assign w_shift    = w_in_xfer || (r_state == S_SCAN);
    assign w_scan_val = w_tap[WINDOW_SIZE-1];
    assign w_head     = w_in_xfer ? w_scaled : w_scan_val;

    for (genvar g = 0; g < WINDOW_SIZE; g++) begin : g_cell
        if (g == 0) begin : g_head
            tmsf_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_data  (w_head),
                .o_data  (w_tap[g])
            );
        end else begin : g_body
            tmsf_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_data  (w_tap[g-1]),
                .o_data  (w_tap[g])
            );
        end
    end

    // running sum / max / min over the tail cell
    assign w_scan_last = (r_cnt == CNT_W'(WINDOW_SIZE - 1));

    always_comb begin
        if (r_cnt == '0) begin
            n_sum = SUM_W'(w_scan_val);
            n_hi  = w_scan_val;
            n_lo  = w_scan_val;
        end else begin
            n_sum = r_sum + SUM_W'(w_scan_val);
            n_hi  = (w_scan_val > r_hi) ? w_scan_val : r_hi;
            n_lo  = (w_scan_val < r_lo) ? w_scan_val : r_lo;
        end
    end

    // divide by WINDOW_SIZE-2: floor reciprocal undershoots by at most one,
    // fixed with one multiply-back and compare
    assign w_prod     = PROD_W'(r_num) * PROD_W'(RECIP);
    assign w_prod_shr = w_prod >> tmsf_pkg::DIV_SHIFT;
    assign w_qd       = r_quo0 * SUM_W'(DIVISOR);
    assign w_rem      = r_num - w_qd;
    assign w_quo      = (w_rem >= SUM_W'(DIVISOR)) ? (r_quo0 + SUM_W'(1)) : r_quo0;

    // voltage offset with saturation, then half-step blend toward previous output
    assign w_val_ext   = r_mode ? ({1'b0, r_mean} + (VAL_W+1)'(tmsf_pkg::VOLT_OFFSET))
                                : {1'b0, r_mean};
    assign w_val       = (w_val_ext > (VAL_W+1)'(tmsf_pkg::VAL_MAX))
                         ? VAL_W'(tmsf_pkg::VAL_MAX) : w_val_ext[VAL_W-1:0];
    assign w_blend_sum = {1'b0, w_val} + {1'b0, r_prev};
    assign w_blend_ext = (w_blend_sum >> 1) + (VAL_W+1)'(1);
    assign w_blend     = (w_blend_ext > (VAL_W+1)'(tmsf_pkg::VAL_MAX))
                         ? VAL_W'(tmsf_pkg::VAL_MAX) : w_blend_ext[VAL_W-1:0];
    assign w_result    = (w_val != r_prev) ? w_blend : w_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_mode      <= 1'b0;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_mode <= i_cfg_data;
            end
            // the blend step reloads the slot itself when it frees up
            if (w_out_xfer && (r_state != S_BLEND)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_cnt   <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_sum <= n_sum;
                    r_hi  <= n_hi;
                    r_lo  <= n_lo;
                    if (w_scan_last) begin
                        r_state <= S_TRIM;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                S_TRIM: begin
                    r_num   <= r_sum - SUM_W'(r_hi) - SUM_W'(r_lo);
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_quo0  <= w_prod_shr[SUM_W-1:0];
                    r_state <= S_FIX;
                end
                S_FIX: begin
                    r_mean  <= w_quo[VAL_W-1:0];
                    r_state <= S_BLEND;
                end
                S_BLEND: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_filt      <= w_result;
                        r_mean_out  <= r_mean;
                        r_prev      <= w_result;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // scan always ends after exactly one full rotation
    a_scan_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && w_scan_last) |=> (r_state == S_TRIM))
        else $error("scan did not end after one rotation");

    // an accepted item starts the scan with the count at zero
    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_state == S_SCAN && r_cnt == '0))
        else $error("scan did not start after input transfer");

    // trimming needs min not above max
    a_min_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TRIM) |-> (r_lo <= r_hi))
        else $error("scan min above max");

    // a blocked output slot parks the blend step and keeps the waiting result
    a_park: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BLEND && r_out_valid && i_out_stall)
        |=> (r_state == S_BLEND && r_out_valid && $stable(r_filt)))
        else $error("result overwritten while output stalled");

endmodule

[rtl/core/tmsf_scale.sv]
module tmsf_scale (
    input  logic                         i_mode,
    input  logic [tmsf_pkg::RAW_W-1:0]   i_raw,
    output logic [tmsf_pkg::VAL_W-1:0]   o_scaled
);

    // 500*255 fits 17 bits; 58986*255 fits 24 bits
    logic [16:0] w_temp_prod;
    logic [16:0] w_temp_shr;
    logic [23:0] w_volt_prod;
    logic [23:0] w_volt_shr;
    logic [tmsf_pkg::VAL_W-1:0] w_temp;

    assign w_temp_prod = 17'(i_raw) * 17'(tmsf_pkg::TEMP_GAIN);
    assign w_temp_shr  = w_temp_prod >> tmsf_pkg::TEMP_SHIFT;
    assign w_temp      = w_temp_shr[tmsf_pkg::VAL_W-1:0];

    assign w_volt_prod = 24'(i_raw) * 24'(tmsf_pkg::VOLT_RECIP);
    assign w_volt_shr  = w_volt_prod >> tmsf_pkg::VOLT_SHIFT;

    always_comb begin
        if (i_mode) begin
            o_scaled = w_volt_shr[tmsf_pkg::VAL_W-1:0];
        end else if (w_temp >= tmsf_pkg::VAL_W'(tmsf_pkg::TEMP_OFFSET)) begin
            o_scaled = w_temp - tmsf_pkg::VAL_W'(tmsf_pkg::TEMP_OFFSET);
        end else begin
            o_scaled = '0;
        end
    end

endmodule

[rtl/core/tmsf_cell.sv]
module tmsf_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_shift,
    input  logic [tmsf_pkg::VAL_W-1:0]   i_data,
    output logic [tmsf_pkg::VAL_W-1:0]   o_data
);

    logic [tmsf_pkg::VAL_W-1:0] r_data;

    // window starts out all zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else if (i_shift) begin
            r_data <= i_data;
        end
    end

    assign o_data = r_data;

endmodule

[sim/trimmed_mean_sensor_filter_unit_tb.sv]
module trimmed_mean_sensor_filter_unit_tb;

    localparam int RAW_W   = tmsf_pkg::RAW_W;
    localparam int VAL_W   = tmsf_pkg::VAL_W;
    localparam int VAL_MAX = tmsf_pkg::VAL_MAX;

    // Scale modes of the one config register
    localparam logic MODE_TEMP = 1'b0;
    localparam logic MODE_VOLT = 1'b1;

    // Receiver stall patterns
    localparam int STALL_NONE   = 0;
    localparam int STALL_RANDOM = 1;
    localparam int STALL_BURSTY = 2;

    localparam int WIN_DEPTH    = tmsf_pkg::WINDOW_SIZE_DEF;
    localparam int LATENCY      = WIN_DEPTH + 4;
    localparam int DRAIN_CYCLES = LATENCY + 4;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int PHASE_ITEMS  = 100;
    localparam int PHASE_COUNT  = 5;

    typedef struct packed {
        logic [VAL_W-1:0] filtered;
        logic [VAL_W-1:0] mean;
    } t_filter_result;

    // DUT ports
    logic             i_clk;
    logic             i_rst_n        = 1'b0;
    logic             i_in_valid     = 1'b0;
    logic             o_in_stall;
    logic [RAW_W-1:0] i_raw_sample   = '0;
    logic             o_out_valid;
    logic             i_out_stall    = 1'b0;
    logic [VAL_W-1:0] o_filtered_value;
    logic [VAL_W-1:0] o_window_mean;
    logic             i_cfg_valid    = 1'b0;
    logic             o_cfg_ready;
    logic             i_cfg_data     = 1'b0;

    // Filter state mirrored from the outside
    logic [VAL_W-1:0] window_cells [WIN_DEPTH];
    int unsigned      fill_slot;
    logic [VAL_W-1:0] last_output;
    logic             mode_shadow;

    t_filter_result   pending_results [$];
    int unsigned      mismatch_count = 0;
    int unsigned      cycle_count    = 0;

    // Receiver control, set by the tests
    int               stall_pattern  = STALL_NONE;
    int               hold_requests  = 0;
    int               hold_served    = 0;
    int               hold_left      = 0;
    int               stall_run      = 0;

    // Sender burst shaping
    bit               gaps_enabled   = 1'b1;
    int               burst_left     = 0;

    trimmed_mean_sensor_filter_unit u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_raw_sample     (i_raw_sample),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_filtered_value (o_filtered_value),
        .o_window_mean    (o_window_mean),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Filter prediction: scale, write into the ring, trimmed mean, blend
    // ------------------------------------------------------------------
    function automatic logic [VAL_W-1:0] scale_reading(logic [RAW_W-1:0] raw);
        int unsigned x;
        int unsigned s;
        x = raw;
        if (mode_shadow == MODE_VOLT) begin
            s = (x * 90) / 50;
        end else begin
            s = (500 * x) >> 8;
            // low temperature reading floors at zero instead of wrapping
            s = (s >= 10) ? s - 10 : 0;
        end
        return s[VAL_W-1:0];
    endfunction

    function automatic t_filter_result predict_filter_output(logic [RAW_W-1:0] raw);
        t_filter_result res;
        int unsigned    hi;
        int unsigned    lo;
        int unsigned    total;
        int unsigned    mean;
        int unsigned    level;
        int unsigned    blended;
        window_cells[fill_slot] = scale_reading(raw);
        fill_slot = (fill_slot == WIN_DEPTH - 1) ? 0 : fill_slot + 1;

        hi    = window_cells[0];
        lo    = window_cells[0];
        total = 0;
        foreach (window_cells[k]) begin
            if (window_cells[k] > hi) begin
                hi = window_cells[k];
            end
            if (window_cells[k] < lo) begin
                lo = window_cells[k];
            end
            total += window_cells[k];
        end
        mean = ((total - hi - lo) / (WIN_DEPTH - 2)) & VAL_MAX;

        // voltage offset saturates at full scale
        level = mean;
        if (mode_shadow == MODE_VOLT) begin
            level = (mean + 7 > VAL_MAX) ? VAL_MAX : mean + 7;
        end

        // half-step blend toward the previous output, also saturating
        if (level != last_output) begin
            blended = (level + last_output) / 2 + 1;
            if (blended > VAL_MAX) begin
                blended = VAL_MAX;
            end
        end else begin
            blended = level;
        end
        last_output  = blended[VAL_W-1:0];
        res.filtered = blended[VAL_W-1:0];
        res.mean     = mean[VAL_W-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every output transfer against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_filter_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: expected no result, got filtered=%0d mean=%0d",
                         $time, o_filtered_value, o_window_mean);
            end else begin
                want = pending_results.pop_front();
                if (o_filtered_value !== want.filtered || o_window_mean !== want.mean) begin
                    mismatch_count++;
                    $display("%0t: expected filtered=%0d mean=%0d, got filtered=%0d mean=%0d",
                             $time, want.filtered, want.mean,
                             o_filtered_value, o_window_mean);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall pattern, plus a long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            case (stall_pattern)
                STALL_NONE: begin
                    i_out_stall <= 1'b0;
                end
                STALL_RANDOM: begin
                    i_out_stall <= ($urandom_range(0, 99) < 35);
                end
                STALL_BURSTY: begin
                    // long runs of stall / no stall of random length
                    if (stall_run == 0) begin
                        stall_run = $urandom_range(1, 24);
                        i_out_stall <= ~i_out_stall;
                    end else begin
                        stall_run--;
                    end
                end
                default: begin
                    i_out_stall <= 1'b0;
                end
            endcase
        end
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("trimmed_mean_sensor_filter_unit: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            i_in_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Offer one sample and hold it until the transfer; valid stays high
    // afterwards until a pause or a drain drops it.
    task automatic send_sample(input logic [RAW_W-1:0] raw);
        if (gaps_enabled) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                pause_sender($urandom_range(0, 8));
            end
            burst_left--;
        end
        i_in_valid   <= 1'b1;
        i_raw_sample <= raw;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        pending_results.push_back(predict_filter_output(raw));
    endtask

    // Stop offering and let every expected result come out
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_scale_mode(input logic mode);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mode;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        mode_shadow = mode;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [RAW_W-1:0] pick_reading();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            case ($urandom_range(0, 3))
                0:       return 8'd0;
                1:       return 8'd255;
                2:       return 8'd1;
                default: return 8'd254;
            endcase
        end else if (roll < 18) begin
            // readings around the temperature offset: 0 to 5 land below it, 6 just above
            return RAW_W'($urandom_range(0, 6));
        end
        return RAW_W'($urandom_range(0, 255));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Extremes of both scalings, the low temperature floor, alternating
    // bits, and a mode change that leaves old-mode entries in the window.
    task automatic test_directed_points();
        logic [RAW_W-1:0] temp_points [8] = '{8'd0, 8'd5, 8'd6, 8'd255,
                                              8'd170, 8'd85, 8'd255, 8'd255};
        logic [RAW_W-1:0] volt_points [8] = '{8'd255, 8'd255, 8'd255, 8'd255,
                                              8'd255, 8'd255, 8'd0, 8'd1};
        gaps_enabled  = 1'b0;
        stall_pattern = STALL_NONE;
        write_scale_mode(MODE_TEMP);
        foreach (temp_points[k]) send_sample(temp_points[k]);
        write_scale_mode(MODE_VOLT);
        foreach (volt_points[k]) send_sample(volt_points[k]);
        // constant input fills the window, so the mean settles on the scaled value and the blend moves toward it
        write_scale_mode(MODE_TEMP);
        repeat (8) send_sample(8'd128);
        wait_drained();
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering
    task automatic test_output_holdoff();
        gaps_enabled  = 1'b0;
        stall_pattern = STALL_NONE;
        hold_requests++;
        for (int n = 0; n < 24; n++) begin
            send_sample(RAW_W'($urandom_range(0, 255)));
        end
        wait_drained();
    endtask

    // Phases of random readings, each under its own mode and idling mix
    task automatic test_random_stream();
        logic [RAW_W-1:0] held_value;
        int               run_left;
        logic             mode;
        run_left   = 0;
        held_value = '0;
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            mode = (phase == PHASE_COUNT - 1) ? logic'($urandom_range(0, 1))
                                              : logic'(phase % 2 == 0);
            write_scale_mode(mode);
            stall_pattern = phase % 3;
            gaps_enabled  = (phase != 1);
            burst_left    = 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (run_left == 0 && $urandom_range(0, 99) < 4) begin
                    // constant runs reach the equal-to-previous case
                    run_left   = $urandom_range(8, 12);
                    held_value = pick_reading();
                end
                if (run_left > 0) begin
                    run_left--;
                    send_sample(held_value);
                end else begin
                    send_sample(pick_reading());
                end
            end
        end
        wait_drained();
    endtask

    initial begin
        foreach (window_cells[k]) window_cells[k] = '0;
        fill_slot   = 0;
        last_output = '0;
        mode_shadow = MODE_TEMP;

        i_rst_n <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_points();
        test_output_holdoff();
        test_random_stream();

        if (mismatch_count == 0) begin
            $display("trimmed_mean_sensor_filter_unit: match");
        end else begin
            $display("trimmed_mean_sensor_filter_unit: mismatch");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/tmsf_pkg.sv
rtl/core/tmsf_scale.sv
rtl/core/tmsf_cell.sv
rtl/core/trimmed_mean_sensor_filter_unit.sv
sim/trimmed_mean_sensor_filter_unit_tb.sv
